[sv/qsl_pkg.sv]
// qsl_pkg: shared types and constants for the quicksort sorter.
// Holds the datapath operation codes and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qsl_pkg;

	// width of the key fields on the channels
	localparam int KEY_W = 32;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_LOAD,
		DP_CLEAR,
		DP_PUSH_ALL,
		DP_POP,
		DP_TAKE_RANGE,
		DP_TAKE_PIVOT,
		DP_READ_JB,
		DP_SWAP1,
		DP_SWAP2,
		DP_SKIP,
		DP_FIN_RD,
		DP_FIN_W1,
		DP_FIN_W2,
		DP_PUSH_R,
		DP_EMIT_START,
		DP_EMIT_RD,
		DP_EMIT_NEXT
	} qsl_op_t;

	typedef struct packed {
		qsl_op_t op;
	} qsl_cmd_t;

	typedef struct packed {
		logic lt2;         // fewer than two keys stored
		logic count_zero;  // no keys stored
		logic sp_zero;     // range stack empty
		logic key_le;      // key[j] <= pivot
		logic j_next_hi;   // j is the last index before the pivot
		logic emit_last;   // emit index is on the last stored key
	} qsl_status_t;

endpackage

`default_nettype wire

[sv/qsl_if.sv]
// qsl_if: valid/ready channel interfaces for the sorter.
// qsl_item_if carries input keys, qsl_result_if carries sorted keys.
// Depends on qsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface qsl_item_if import qsl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [KEY_W-1:0] key;
	logic             final_key;

	modport source (output valid, output key, output final_key, input ready);
	modport sink (input valid, input key, input final_key, output ready);
endinterface

interface qsl_result_if import qsl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [KEY_W-1:0] sorted_key;
	logic             final_out;

	modport source (output valid, output sorted_key, output final_out, input ready);
	modport sink (input valid, input sorted_key, input final_out, output ready);
endinterface

`default_nettype wire

[sv/quicksort_lomuto_sorter_unit.sv]
// Channel   Dir  Payload                       Transfer
// items     in   key[31:0], final_key          valid && ready
// sorted    out  sorted_key[31:0], final_out   valid && ready
//
// Loading accepts one key per cycle; the key with final_key set closes the set.
// Sorting runs the Lomuto partition loop range by range, bound by the single
// write port of the key store. Emitting reads each key from the store, then
// offers it on the output; a stalled output holds the datapath. Input is
// refused from set close to last transfer.
// Reset clears the key count and stack pointer; no clearing pass is needed.
// Depends on qsl_pkg, qsl_if, qsl_controller, qsl_datapath.
`timescale 1ns / 1ps
`default_nettype none

module quicksort_lomuto_sorter_unit import qsl_pkg::*; #(
	parameter int MAX_KEYS = 64,
	parameter int KEY_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	qsl_item_if.sink    items,
	qsl_result_if.source sorted
);

	qsl_cmd_t    cmd;
	qsl_status_t status;

	qsl_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_final  (items.final_key),
		.in_ready  (items.ready),
		.out_valid (sorted.valid),
		.out_ready (sorted.ready),
		.status    (status),
		.cmd       (cmd)
	);

	qsl_datapath #(
		.MAX_KEYS (MAX_KEYS),
		.KEY_BITS (KEY_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.in_key  (items.key),
		.status  (status),
		.out_key (sorted.sorted_key)
	);

	assign sorted.final_out = status.emit_last;

	// loading and emitting never overlap
	a_phase_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(items.ready && sorted.valid))
		else $error("input ready while output valid");

	a_close_stops_load: assert property (@(posedge clk) disable iff (!arst_n)
		(items.valid && items.ready && items.final_key) |=> !items.ready)
		else $error("input still ready after set close");

	a_last_reloads: assert property (@(posedge clk) disable iff (!arst_n)
		(sorted.valid && sorted.ready && sorted.final_out) |=> items.ready)
		else $error("not back to loading after last transfer");

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		sorted.valid |-> !status.count_zero)
		else $error("output valid with empty store");

endmodule

`default_nettype wire

[sv/qsl_datapath.sv]
// qsl_datapath: key store, range stack, partition registers and emit index.
// Executes one qsl_op_t per cycle; memories have registered read data.
// Depends on qsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qsl_datapath import qsl_pkg::*; #(
	parameter int MAX_KEYS = 64,
	parameter int KEY_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  qsl_cmd_t          cmd,
	input  logic [KEY_W-1:0]  in_key,
	output qsl_status_t       status,
	output logic [KEY_W-1:0]  out_key
);

	localparam int AW  = $clog2(MAX_KEYS);
	localparam int CW  = $clog2(MAX_KEYS + 1);
	localparam int SD  = MAX_KEYS / 2;
	localparam int SPW = $clog2(SD + 1);
	localparam int SAW = (SD > 1) ? $clog2(SD) : 1;

	logic [KEY_BITS-1:0] key_mem [MAX_KEYS];
	logic [2*AW-1:0]     stk_mem [SD];

	logic [CW-1:0]       count_q;
	logic [SPW-1:0]      sp_q;
	logic [AW-1:0]       lo_q, hi_q, j_q, bound_q, k_q;
	logic [KEY_BITS-1:0] pivot_q, rd_a_q, rd_b_q;
	logic [2*AW-1:0]     stk_rd_q;

	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [KEY_BITS-1:0] mem_wdata;
	logic                re_a, re_b;
	logic [AW-1:0]       addr_a, addr_b;
	logic                stk_we, stk_push, stk_re;
	logic [2*AW-1:0]     stk_wdata;
	logic [SPW-1:0]      sp_dec;
	logic                push_l_ok, push_r_ok, stack_full, full;

	assign full       = (count_q == CW'(MAX_KEYS));
	assign stack_full = (sp_q == SPW'(SD));
	assign sp_dec     = sp_q - SPW'(1);
	// subranges of one key are not pushed
	assign push_l_ok  = ({1'b0, bound_q} - {1'b0, lo_q}) >= (AW+1)'(2);
	assign push_r_ok  = ({1'b0, hi_q} - {1'b0, bound_q}) >= (AW+1)'(2);
	assign stk_push   = stk_we && !stack_full;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = bound_q;
		mem_wdata = rd_a_q;
		re_a      = 1'b0;
		re_b      = 1'b0;
		addr_a    = j_q;
		addr_b    = bound_q;
		stk_we    = 1'b0;
		stk_re    = 1'b0;
		stk_wdata = {lo_q, hi_q};
		case (cmd.op)
			DP_LOAD: begin
				mem_we    = !full;
				mem_waddr = count_q[AW-1:0];
				mem_wdata = KEY_BITS'(in_key);
			end
			DP_PUSH_ALL: begin
				stk_we    = 1'b1;
				stk_wdata = {AW'(0), AW'(count_q - CW'(1))};
			end
			DP_POP: stk_re = 1'b1;
			DP_TAKE_RANGE: begin
				re_a   = 1'b1;
				addr_a = stk_rd_q[AW-1:0];
			end
			DP_READ_JB: begin
				re_a = 1'b1;
				re_b = 1'b1;
			end
			DP_SWAP1: mem_we = 1'b1;
			DP_SWAP2: begin
				mem_we    = 1'b1;
				mem_waddr = j_q;
				mem_wdata = rd_b_q;
			end
			DP_FIN_RD: re_b = 1'b1;
			DP_FIN_W1: begin
				mem_we    = 1'b1;
				mem_wdata = pivot_q;
			end
			DP_FIN_W2: begin
				mem_we    = 1'b1;
				mem_waddr = hi_q;
				mem_wdata = rd_b_q;
				stk_we    = push_l_ok;
				stk_wdata = {lo_q, bound_q - AW'(1)};
			end
			DP_PUSH_R: begin
				stk_we    = push_r_ok;
				stk_wdata = {bound_q + AW'(1), hi_q};
			end
			DP_EMIT_RD: begin
				re_a   = 1'b1;
				addr_a = k_q;
			end
			default: ;
		endcase
	end

	// memories, no reset
	always_ff @(posedge clk) begin
		if (mem_we)
			key_mem[mem_waddr] <= mem_wdata;
		if (re_a)
			rd_a_q <= key_mem[addr_a];
		if (re_b)
			rd_b_q <= key_mem[addr_b];
		if (stk_push)
			stk_mem[sp_q[SAW-1:0]] <= stk_wdata;
		if (stk_re)
			stk_rd_q <= stk_mem[sp_dec[SAW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sp_q    <= '0;
		end else begin
			if (cmd.op == DP_CLEAR) begin
				count_q <= '0;
				sp_q    <= '0;
			end else begin
				if (cmd.op == DP_LOAD && !full)
					count_q <= count_q + CW'(1);
				if (stk_push)
					sp_q <= sp_q + SPW'(1);
				else if (stk_re)
					sp_q <= sp_dec;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_TAKE_RANGE: begin
				lo_q <= stk_rd_q[2*AW-1:AW];
				hi_q <= stk_rd_q[AW-1:0];
			end
			DP_TAKE_PIVOT: begin
				pivot_q <= rd_a_q;
				j_q     <= lo_q;
				bound_q <= lo_q;
			end
			DP_SWAP2: begin
				j_q     <= j_q + AW'(1);
				bound_q <= bound_q + AW'(1);
			end
			DP_SKIP: j_q <= j_q + AW'(1);
			DP_EMIT_START: k_q <= '0;
			DP_EMIT_NEXT: k_q <= k_q + AW'(1);
			default: ;
		endcase
	end

	assign status.lt2        = (count_q < CW'(2));
	assign status.count_zero = (count_q == '0);
	assign status.sp_zero    = (sp_q == '0);
	assign status.key_le     = (rd_a_q <= pivot_q);
	assign status.j_next_hi  = ((j_q + AW'(1)) == hi_q);
	assign status.emit_last  = ((CW'(k_q) + CW'(1)) == count_q);

	assign out_key = KEY_W'(rd_a_q);

endmodule

`default_nettype wire

[sv/qsl_controller.sv]
// qsl_controller: sequencer for load, Lomuto partition and emit.
// Issues one datapath command per cycle from its state and the datapath status.
// Depends on qsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qsl_controller import qsl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_final,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  qsl_status_t status,
	output qsl_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_LOAD,
		S_SORT_INIT,
		S_POP,
		S_RANGE,
		S_PIVOT,
		S_READ,
		S_CMP,
		S_SWAP,
		S_FIN_RD,
		S_FIN_W1,
		S_FIN_W2,
		S_PUSH_R,
		S_EMIT_CHK,
		S_EMIT_RD,
		S_EMIT_OUT
	} state_t;

	state_t state_q, state_d;
	logic   in_ready_q, out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd.op  = DP_NOP;
		case (state_q)
			S_LOAD: begin
				if (in_ready_q && in_valid) begin
					cmd.op = DP_LOAD;
					if (in_final)
						state_d = S_SORT_INIT;
				end
			end
			S_SORT_INIT: begin
				if (status.lt2) begin
					state_d = S_EMIT_CHK;
				end else begin
					cmd.op  = DP_PUSH_ALL;
					state_d = S_POP;
				end
			end
			S_POP: begin
				if (status.sp_zero) begin
					state_d = S_EMIT_CHK;
				end else begin
					cmd.op  = DP_POP;
					state_d = S_RANGE;
				end
			end
			S_RANGE: begin
				cmd.op  = DP_TAKE_RANGE;
				state_d = S_PIVOT;
			end
			S_PIVOT: begin
				cmd.op  = DP_TAKE_PIVOT;
				state_d = S_READ;
			end
			S_READ: begin
				cmd.op  = DP_READ_JB;
				state_d = S_CMP;
			end
			S_CMP: begin
				if (status.key_le) begin
					cmd.op  = DP_SWAP1;
					state_d = S_SWAP;
				end else begin
					cmd.op  = DP_SKIP;
					state_d = status.j_next_hi ? S_FIN_RD : S_READ;
				end
			end
			S_SWAP: begin
				cmd.op  = DP_SWAP2;
				state_d = status.j_next_hi ? S_FIN_RD : S_READ;
			end
			S_FIN_RD: begin
				cmd.op  = DP_FIN_RD;
				state_d = S_FIN_W1;
			end
			S_FIN_W1: begin
				cmd.op  = DP_FIN_W1;
				state_d = S_FIN_W2;
			end
			S_FIN_W2: begin
				cmd.op  = DP_FIN_W2;
				state_d = S_PUSH_R;
			end
			S_PUSH_R: begin
				cmd.op  = DP_PUSH_R;
				state_d = S_POP;
			end
			S_EMIT_CHK: begin
				if (status.count_zero) begin
					cmd.op  = DP_CLEAR;
					state_d = S_LOAD;
				end else begin
					cmd.op  = DP_EMIT_START;
					state_d = S_EMIT_RD;
				end
			end
			S_EMIT_RD: begin
				cmd.op  = DP_EMIT_RD;
				state_d = S_EMIT_OUT;
			end
			S_EMIT_OUT: begin
				if (out_valid_q && out_ready) begin
					if (status.emit_last) begin
						cmd.op  = DP_CLEAR;
						state_d = S_LOAD;
					end else begin
						cmd.op  = DP_EMIT_NEXT;
						state_d = S_EMIT_RD;
					end
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			in_ready_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			in_ready_q  <= (state_d == S_LOAD);
			out_valid_q <= (state_d == S_EMIT_OUT);
		end
	end

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

[sim/quicksort_lomuto_sorter_unit_tb.sv]
// Testbench for quicksort_lomuto_sorter_unit: drives sets of keys and checks each sorted run.
// Keys are sorted by a local Lomuto quicksort when a set closes. Each output transfer is
// checked against that result. Depends on qsl_pkg, qsl_if and the sorter RTL.
`timescale 1ns / 1ps
`default_nettype none

module quicksort_lomuto_sorter_unit_tb;
	import qsl_pkg::*;

	localparam int MAX_KEYS    = 64;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_WAIT  = 300;
	localparam int PHASE_ITEMS = 136;

	typedef enum int {
		SET_RANDOM,
		SET_RISING,
		SET_FALLING,
		SET_FLAT,
		SET_EXTREMES,
		SET_NARROW
	} set_shape_t;

	typedef struct {
		logic [KEY_W-1:0] key;
		logic             last;
		int               gap_pct;    // sender idle chance while this key waits
		int               stall_pct;  // receiver stall chance from its transfer on
		logic             hold;       // wait for all sorted keys before sending
	} key_feed_t;

	typedef struct {
		logic [KEY_W-1:0] key;
		logic             last;
	} sorted_key_t;

	logic clk;
	logic arst_n = 1'b0;

	qsl_item_if   items_ch ();
	qsl_result_if sorted_ch ();

	quicksort_lomuto_sorter_unit #(
		.MAX_KEYS(MAX_KEYS),
		.KEY_BITS(KEY_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_ch),
		.sorted(sorted_ch)
	);

	key_feed_t        key_feed_q[$];
	sorted_key_t      sorted_keys_q[$];
	logic [KEY_W-1:0] loaded_keys[$];
	logic             item_taken = 1'b0;
	int               stall_pct = 0;
	int               error_count = 0;
	int               cycle_count = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report_mismatch(input string what, input logic [KEY_W-1:0] want,
			input logic [KEY_W-1:0] got);
		error_count++;
		$display("%0t mismatch %s: expected %h, got %h", $time, what, want, got);
	endtask

	// Lomuto quicksort over the stored keys, pending ranges on an explicit stack
	function automatic void sort_loaded_keys();
		int lo_stack[$];
		int hi_stack[$];
		int lo, hi, bound;
		logic [KEY_W-1:0] pivot, tmp;
		if (loaded_keys.size() < 2)
			return;
		lo_stack.push_back(0);
		hi_stack.push_back(loaded_keys.size() - 1);
		while (lo_stack.size() != 0) begin
			lo = lo_stack.pop_back();
			hi = hi_stack.pop_back();
			pivot = loaded_keys[hi];
			bound = lo;
			for (int j = lo; j < hi; j++) begin
				if (loaded_keys[j] <= pivot) begin
					tmp = loaded_keys[bound];
					loaded_keys[bound] = loaded_keys[j];
					loaded_keys[j] = tmp;
					bound++;
				end
			end
			tmp = loaded_keys[bound];
			loaded_keys[bound] = loaded_keys[hi];
			loaded_keys[hi] = tmp;
			if (bound - 1 > lo) begin
				lo_stack.push_back(lo);
				hi_stack.push_back(bound - 1);
			end
			if (bound + 1 < hi) begin
				lo_stack.push_back(bound + 1);
				hi_stack.push_back(hi);
			end
		end
	endfunction

	function automatic void load_key(input logic [KEY_W-1:0] key, input logic last);
		sorted_key_t run_entry;
		// a full store drops the key, but a final mark still closes the set
		if (loaded_keys.size() < MAX_KEYS)
			loaded_keys.push_back(key);
		if (!last)
			return;
		sort_loaded_keys();
		foreach (loaded_keys[k]) begin
			run_entry.key = loaded_keys[k];
			run_entry.last = (k == loaded_keys.size() - 1);
			sorted_keys_q.push_back(run_entry);
		end
		loaded_keys.delete();
	endfunction

	task automatic add_keys(input logic [KEY_W-1:0] vals[$], input int gap, input int stall,
			input logic hold);
		key_feed_t feed;
		foreach (vals[i]) begin
			feed.key = vals[i];
			feed.last = (i == vals.size() - 1);
			feed.gap_pct = gap;
			feed.stall_pct = stall;
			feed.hold = hold && (i == 0);
			key_feed_q.push_back(feed);
		end
	endtask

	task automatic add_random_set(input int n, input set_shape_t shape, input int gap,
			input int stall, input logic hold);
		logic [KEY_W-1:0] vals[$];
		logic [KEY_W-1:0] base;
		base = $urandom;
		for (int i = 0; i < n; i++) begin
			case (shape)
				SET_FLAT: begin
					vals.push_back(base);
				end
				SET_EXTREMES: begin
					case ($urandom_range(2))
						0: vals.push_back('0);
						1: vals.push_back('1);
						default: vals.push_back(base);
					endcase
				end
				SET_NARROW: begin
					vals.push_back(KEY_W'($urandom_range(15)));
				end
				default: begin
					vals.push_back($urandom);
				end
			endcase
		end
		if (shape == SET_RISING)
			vals.sort();
		else if (shape == SET_FALLING)
			vals.rsort();
		add_keys(vals, gap, stall, hold);
	endtask

	// item side: prediction and queue pop on each transfer
	always @(posedge clk) begin
		if (arst_n && items_ch.valid && items_ch.ready) begin
			load_key(items_ch.key, items_ch.final_key);
			stall_pct = key_feed_q[0].stall_pct;
			void'(key_feed_q.pop_front());
			item_taken <= 1'b1;
		end else begin
			item_taken <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			items_ch.valid <= 1'b0;
		end else if (items_ch.valid && !item_taken) begin
			// transfer still pending: keep the key on the bus
		end else if (key_feed_q.size() != 0 &&
				!(key_feed_q[0].hold && sorted_keys_q.size() != 0) &&
				$urandom_range(99) >= key_feed_q[0].gap_pct) begin
			items_ch.valid <= 1'b1;
			items_ch.key <= key_feed_q[0].key;
			items_ch.final_key <= key_feed_q[0].last;
		end else begin
			items_ch.valid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		sorted_ch.ready <= arst_n && ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		sorted_key_t want;
		if (arst_n && sorted_ch.valid && sorted_ch.ready) begin
			if (sorted_keys_q.size() == 0) begin
				report_mismatch("unexpected sorted key", '0, sorted_ch.sorted_key);
			end else begin
				want = sorted_keys_q.pop_front();
				if (sorted_ch.sorted_key !== want.key)
					report_mismatch("sorted_key", want.key, sorted_ch.sorted_key);
				if (sorted_ch.final_out !== want.last)
					report_mismatch("final_out", KEY_W'(want.last), KEY_W'(sorted_ch.final_out));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		logic [KEY_W-1:0] dir_vals[$];
		int gap_pct[3];
		int rx_pct[3];
		int phase_start, n, r;
		gap_pct = '{20, 52, 0};
		rx_pct = '{52, 20, 0};
		items_ch.valid = 1'b0;
		items_ch.key = '0;
		items_ch.final_key = 1'b0;
		sorted_ch.ready = 1'b0;

		// single-key sets at both ends of the range
		dir_vals = {32'h0000_0000};
		add_keys(dir_vals, 0, 0, 1'b0);
		dir_vals = {32'hFFFF_FFFF};
		add_keys(dir_vals, 0, 0, 1'b0);
		dir_vals = {32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h1,
			32'h7FFF_FFFF};
		add_keys(dir_vals, 0, 0, 1'b0);
		dir_vals = {32'h5, 32'h5, 32'h5, 32'h5};
		add_keys(dir_vals, 0, 0, 1'b0);
		dir_vals = {32'h9, 32'h8, 32'h7, 32'h6, 32'h5, 32'h4, 32'h3};
		add_keys(dir_vals, 0, 0, 1'b0);
		dir_vals = {32'h2, 32'h1};
		add_keys(dir_vals, 0, 0, 1'b0);
		dir_vals = {32'h1, 32'h2};
		add_keys(dir_vals, 0, 0, 1'b0);

		for (int p = 0; p < 3; p++) begin
			phase_start = key_feed_q.size();
			// one large set per phase; the first overruns the store
			case (p)
				0: add_random_set(MAX_KEYS + 6, SET_RANDOM, gap_pct[p], rx_pct[p], 1'b1);
				1: add_random_set(MAX_KEYS, SET_FALLING, gap_pct[p], rx_pct[p], 1'b1);
				default: add_random_set(MAX_KEYS, SET_RISING, gap_pct[p], rx_pct[p], 1'b1);
			endcase
			while (key_feed_q.size() - phase_start < PHASE_ITEMS) begin
				r = $urandom_range(99);
				if (r < 4)
					n = $urandom_range(MAX_KEYS, MAX_KEYS + 6);
				else if (r < 20)
					n = $urandom_range(17, 40);
				else
					n = $urandom_range(1, 16);
				add_random_set(n, set_shape_t'($urandom_range(5)), gap_pct[p], rx_pct[p],
					$urandom_range(99) < 8);
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (key_feed_q.size() != 0 || sorted_keys_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		while (sorted_keys_q.size() != 0) begin
			report_mismatch("sorted key never sent", sorted_keys_q[0].key, 'x);
			void'(sorted_keys_q.pop_front());
		end
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
